// ===== hdl/diff_drive_odometry_macros.svh =====
// Assertion macros shared by the odometry RTL
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH

// Check that an implication holds at every clock edge outside reset
`define ODO_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define ODO_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/ddo_pkg.sv =====
package ddo_pkg;

    localparam int CordicSteps = 24;
    localparam int StepW = $clog2(CordicSteps + 1);

    localparam logic signed [31:0] PiQ28 = 32'sd843314857;
    localparam logic signed [31:0] TwoPiQ28 = 32'sd1686629714;
    localparam logic signed [33:0] HalfPiQ30 = 34'sd1686629714;
    localparam logic signed [33:0] PiQ30 = 34'sd3373259428;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    localparam logic [1:0] RegDist = 2'd0;
    localparam logic [1:0] RegInvTw = 2'd1;
    localparam logic [1:0] RegRate = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DR,
        ST_DL,
        ST_DTH,
        ST_RS,
        ST_LS,
        ST_ANG,
        ST_CORDIC,
        ST_XSTEP,
        ST_YSTEP,
        ST_OUT
    } ddo_state_t;

    // CORDIC arctangent table, Q2.30
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        begin
            unique case (i)
                5'd0: v = 34'sd843314857;
                5'd1: v = 34'sd497837829;
                5'd2: v = 34'sd263043837;
                5'd3: v = 34'sd133525159;
                5'd4: v = 34'sd67021687;
                5'd5: v = 34'sd33543516;
                5'd6: v = 34'sd16775851;
                5'd7: v = 34'sd8388437;
                5'd8: v = 34'sd4194283;
                5'd9: v = 34'sd2097149;
                5'd31: v = 34'sd0;
                default: v = 34'sd1 <<< (5'd30 - i);
            endcase
            atan_q30 = v;
        end
    endfunction

endpackage

// ===== hdl/ddo_cordic.sv =====
module ddo_cordic
    import ddo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [33:0]  angle,
    output logic                done,
    output logic signed [33:0]  cos_out,
    output logic signed [33:0]  sin_out
);

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [StepW-1:0] step_reg;
    logic busy_reg, flip_reg, done_reg;
    logic signed [33:0] xs, ys;
    logic [4:0] idx;

    assign idx = 5'(step_reg);
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;

    // Run one rotation step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                x_reg <= CordicGain;
                y_reg <= '0;
                if (angle > HalfPiQ30)
                begin
                    z_reg <= angle - PiQ30;
                    flip_reg <= 1'b1;
                end
                else if (angle < -HalfPiQ30)
                begin
                    z_reg <= angle + PiQ30;
                    flip_reg <= 1'b1;
                end
                else
                begin
                    z_reg <= angle;
                    flip_reg <= 1'b0;
                end
            end
            else if (busy_reg)
            begin
                if (step_reg == StepW'(CordicSteps))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                    if (!z_reg[33])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_q30(idx);
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_q30(idx);
                    end
                end
            end
        end
    end

    assign done = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

// ===== hdl/diff_drive_odometry.sv =====
// Sequence: an accepted input word passes through the accept cycle, six multiplier steps,
// the CORDIC (24 rotation steps, one per cycle, plus start and finish), two position
// steps and the output step before its result word shows on m_tvalid. A new word is
// accepted only after the output step. A held result word stalls the next word there.
// Reset: pose, previous counts and handshake clear; registers take their
// documented defaults.
`include "diff_drive_odometry_macros.svh"
module diff_drive_odometry
    import ddo_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // right_count[31:0], left_count[63:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [223:0] m_tdata,   // x_pos, y_pos, heading_out(31), rs, ls, lin, ang, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ddo_state_t state_reg, state_next;
    logic [31:0] dist_reg;
    logic [23:0] invtw_reg;
    logic [15:0] rate_reg;
    logic [31:0] prev_r_reg, prev_l_reg, cnt_r_reg, cnt_l_reg;
    logic signed [31:0] x_reg, y_reg, th_reg;
    logic signed [33:0] dr_reg, dl_reg, dth_reg;
    logic signed [31:0] rs_reg, ls_reg, ang_reg;
    logic signed [33:0] cos_v, sin_v;
    logic cordic_done, cordic_start;
    logic out_valid_reg;
    logic [223:0] out_reg;
    logic out_load;

    // Shared multiplier: 35x33 signed
    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] prod;
    assign prod = mul_a * mul_b;

    logic signed [32:0] dcr, dcl;
    assign dcr = 33'(signed'(cnt_r_reg - prev_r_reg));
    assign dcl = 33'(signed'(cnt_l_reg - prev_l_reg));

    logic signed [34:0] dsum;
    logic signed [33:0] ds;
    assign dsum = 35'(dr_reg) + 35'(dl_reg);
    assign ds = dsum[34:1];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DR:    begin mul_a = 35'(dcr); mul_b = {1'b0, dist_reg}; end
            ST_DL:    begin mul_a = -35'(dcl); mul_b = {1'b0, dist_reg}; end
            ST_DTH:   begin mul_a = 35'(dr_reg) - 35'(dl_reg); mul_b = 33'({1'b0, invtw_reg}); end
            ST_RS:    begin mul_a = 35'(dr_reg); mul_b = 33'({1'b0, rate_reg}); end
            ST_LS:    begin mul_a = 35'(dl_reg); mul_b = 33'({1'b0, rate_reg}); end
            ST_ANG:   begin mul_a = 35'(dth_reg); mul_b = 33'({1'b0, rate_reg}); end
            ST_XSTEP: begin mul_a = 35'(ds); mul_b = 33'(cos_v); end
            ST_YSTEP: begin mul_a = 35'(ds); mul_b = 33'(sin_v); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    function automatic logic signed [33:0] sat34(input logic signed [67:0] v);
        if (v > 68'sd4294967295) sat34 = 34'sd4294967295;
        else if (v < -68'sd4294967296) sat34 = -34'sd4294967296;
        else sat34 = v[33:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) sat32 = 32'sh7fffffff;
        else if (v < -68'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction

    logic signed [67:0] p4, p12, p16, pstep;
    assign p4 = prod >>> 4;
    assign p12 = prod >>> 12;
    assign p16 = prod >>> 16;
    assign pstep = (prod + (68'sd1 <<< 41)) >>> 42;

    // New heading with one wrap
    logic signed [33:0] th_sum, th_new;
    assign th_sum = 34'(th_reg) + dth_reg;
    always_comb
    begin
        th_new = th_sum;
        if (th_sum > 34'(PiQ28)) th_new = th_sum - 34'(TwoPiQ28);
        if (th_new < -34'(PiQ28)) th_new = th_new + 34'(TwoPiQ28);
    end

    assign cordic_start = (state_reg == ST_ANG);

    ddo_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cordic_start),
        .angle(34'(th_reg) <<< 2),
        .done(cordic_done), .cos_out(cos_v), .sin_out(sin_v)
    );

    // Load the output register once the previous result word has left
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    // Sequence one word through the shared multiplier and CORDIC
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_DR;
            ST_DR:     state_next = ST_DL;
            ST_DL:     state_next = ST_DTH;
            ST_DTH:    state_next = ST_RS;
            ST_RS:     state_next = ST_LS;
            ST_LS:     state_next = ST_ANG;
            ST_ANG:    state_next = ST_CORDIC;
            ST_CORDIC: if (cordic_done) state_next = ST_XSTEP;
            ST_XSTEP:  state_next = ST_YSTEP;
            ST_YSTEP:  state_next = ST_OUT;
            ST_OUT:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dist_reg <= 32'd69578;
            invtw_reg <= 24'd327680;
            rate_reg <= 16'd250;
            prev_r_reg <= '0;
            prev_l_reg <= '0;
            x_reg <= '0;
            y_reg <= '0;
            th_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // Register writes
            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    RegDist:  dist_reg <= pwdata;
                    RegInvTw: invtw_reg <= pwdata[23:0];
                    RegRate:  rate_reg <= pwdata[15:0];
                    default:  ;
                endcase
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (s_tvalid)
                    begin
                        cnt_r_reg <= s_tdata[31:0];
                        cnt_l_reg <= s_tdata[63:32];
                    end
                ST_DR:
                begin
                    dr_reg <= sat34(p4);
                    prev_r_reg <= cnt_r_reg;
                end
                ST_DL:
                begin
                    dl_reg <= sat34(p4);
                    prev_l_reg <= cnt_l_reg;
                end
                ST_DTH:
                begin
                    if (p16 > 68'(PiQ28)) dth_reg <= 34'(PiQ28);
                    else if (p16 < -68'(PiQ28)) dth_reg <= -34'(PiQ28);
                    else dth_reg <= p16[33:0];
                end
                ST_RS: rs_reg <= sat32(p12);
                ST_LS:
                begin
                    ls_reg <= sat32(p12);
                    th_reg <= th_new[31:0];
                end
                ST_ANG: ang_reg <= sat32(p12);
                ST_XSTEP: x_reg <= sat32(68'(x_reg) + pstep);
                ST_YSTEP: y_reg <= sat32(68'(y_reg) + pstep);
                ST_OUT:
                begin
                    if (out_load)
                        out_reg <= {1'b0, ang_reg,
                                    32'((33'(rs_reg) + 33'(ls_reg)) >>> 1),
                                    ls_reg, rs_reg,
                                    th_reg[30:0], y_reg, x_reg};
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;
    assign pready = 1'b1;

    // Register read
    always_comb
    begin
        unique case (paddr[3:2])
            RegDist:  prdata = dist_reg;
            RegInvTw: prdata = {8'd0, invtw_reg};
            RegRate:  prdata = {16'd0, rate_reg};
            default:  prdata = '0;
        endcase
    end

    `ODO_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !s_tready, "accept while busy")
    `ODO_ASSERT_IMP(a_heading_range, clk, rst_n, 1'b1, (th_reg <= PiQ28) && (th_reg >= -PiQ28), "heading out of range")
    `ODO_ASSERT_NEXT(a_out_set, clk, rst_n, state_reg == ST_OUT, m_tvalid, "result not shown")

endmodule

// ===== bench/diff_drive_odometry_test.sv =====
module diff_drive_odometry_test;
    import ddo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GapMax = 18;
    localparam int SettleCycles = 60;
    localparam int WatchdogLimit = 4000;
    localparam int PhaseCount = 9;
    localparam int ItemsPerPhase = 200;
    localparam logic [3:0] AddrDist = 4'(RegDist) << 2;
    localparam logic [3:0] AddrInvTw = 4'(RegInvTw) << 2;
    localparam logic [3:0] AddrRate = 4'(RegRate) << 2;
    localparam logic [3:0] AddrUnused = 4'd12;
    localparam longint PiFix = 843314857;
    localparam longint GainFix = 652032874;
    localparam longint DistHi = 64'sd4294967295;
    localparam longint DistLo = -64'sd4294967296;

    typedef struct packed {
        logic signed [31:0] ang;
        logic signed [31:0] lin;
        logic signed [31:0] ls;
        logic signed [31:0] rs;
        logic signed [30:0] heading;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } pose_t;

    typedef struct {
        logic signed [31:0] right;
        logic signed [31:0] left;
        bit                 fixed;
        pose_t              pose;
    } tick_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;    // right_count[31:0], left_count[63:32]
    logic         m_tvalid;
    logic         m_tready;
    logic [223:0] m_tdata;    // x_pos, y_pos, heading_out(31), rs, ls, lin, ang, pad
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Predictor copy of registers and pose state
    logic [31:0]  dist_reg;
    logic [23:0]  invtw_reg;
    logic [15:0]  rate_reg;
    logic [31:0]  last_right;
    logic [31:0]  last_left;
    logic signed [31:0] x_state;
    logic signed [31:0] y_state;
    logic signed [31:0] heading_state;

    pose_t   pose_queue[$];
    int      errors;
    int      idle_cycles;
    bit      no_stall;
    logic [31:0] gen_right;
    logic [31:0] gen_left;

    longint atan_tab[32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
        128, 64, 32, 16, 8, 4, 2, 1, 0
    };

    diff_drive_odometry dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat32(longint v);
        return clamp64(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint wrap_delta(logic [31:0] now, logic [31:0] prev);
        logic signed [31:0] d;
        d = now - prev;
        return longint'(d);
    endfunction

    // Rotate the gain vector by the heading, Q2.30 in and out
    task automatic rotate(input longint angle, output longint cs, output longint sn);
        longint xv;
        longint yv;
        longint zv;
        longint nx;
        bit     flip;
        xv = GainFix;
        yv = 0;
        zv = angle;
        flip = 0;
        if (zv > 2 * PiFix)
        begin
            zv -= 4 * PiFix;
            flip = 1;
        end
        else if (zv < -2 * PiFix)
        begin
            zv += 4 * PiFix;
            flip = 1;
        end
        for (int i = 0; i < CordicSteps && i < 32; i++)
        begin
            if (zv >= 0)
            begin
                nx = xv - (yv >>> i);
                yv = yv + (xv >>> i);
                zv -= atan_tab[i];
            end
            else
            begin
                nx = xv + (yv >>> i);
                yv = yv - (xv >>> i);
                zv += atan_tab[i];
            end
            xv = nx;
        end
        cs = flip ? -xv : xv;
        sn = flip ? -yv : yv;
    endtask

    // Advance the pose by one tick of encoder counts
    task automatic odometry_step(input logic [31:0] r, input logic [31:0] l,
                                 output pose_t p);
        longint dr_cnt;
        longint dl_cnt;
        longint dr;
        longint dl;
        longint dth;
        longint ds;
        longint th;
        longint rs;
        longint ls;
        longint cs;
        longint sn;
        dr_cnt = wrap_delta(r, last_right);
        dl_cnt = wrap_delta(l, last_left);
        last_right = r;
        last_left = l;
        dr = clamp64((dr_cnt * longint'(dist_reg)) >>> 4, DistLo, DistHi);
        dl = clamp64((-(dl_cnt * longint'(dist_reg))) >>> 4, DistLo, DistHi);
        dth = clamp64(((dr - dl) * longint'(invtw_reg)) >>> 16, -PiFix, PiFix);
        ds = (dr + dl) >>> 1;
        rs = sat32((dr * longint'(rate_reg)) >>> 12);
        ls = sat32((dl * longint'(rate_reg)) >>> 12);
        p.rs = rs[31:0];
        p.ls = ls[31:0];
        p.lin = 32'((rs + ls) >>> 1);
        p.ang = 32'(sat32((dth * longint'(rate_reg)) >>> 12));
        th = longint'(heading_state) + dth;
        if (th > PiFix)
            th -= 2 * PiFix;
        if (th < -PiFix)
            th += 2 * PiFix;
        heading_state = th[31:0];
        rotate(th * 4, cs, sn);
        x_state = 32'(sat32(longint'(x_state) + ((ds * cs + (64'sd1 <<< 41)) >>> 42)));
        y_state = 32'(sat32(longint'(y_state) + ((ds * sn + (64'sd1 <<< 41)) >>> 42)));
        p.x = x_state;
        p.y = y_state;
        p.heading = heading_state[30:0];
    endtask

    task automatic reg_write(input logic [3:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (addr)
            AddrDist: dist_reg = value;
            AddrInvTw: invtw_reg = value[23:0];
            AddrRate: rate_reg = value[15:0];
            default: ;
        endcase
    endtask

    // Wait out all results and the tail of the block's work
    task automatic drain();
        while (pose_queue.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic send_tick(input logic [31:0] r, input logic [31:0] l,
                             input bit fixed, input pose_t fixed_pose);
        int    gap;
        pose_t p;
        gap = no_stall ? 0 : $urandom_range(GapMax, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {l, r};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        odometry_step(r, l, p);
        pose_queue.push_back(fixed ? fixed_pose : p);
    endtask

    // Mostly plausible motion, with some jumps across the whole range
    task automatic send_random();
        int span;
        if ($urandom_range(99, 0) < 85)
        begin
            span = ($urandom_range(9, 0) == 0) ? 400000 : 3000;
            gen_right = gen_right + 32'($urandom_range(2 * span, 0) - span);
            gen_left = gen_left + 32'($urandom_range(2 * span, 0) - span);
        end
        else
        begin
            gen_right = $urandom();
            gen_left = $urandom();
        end
        send_tick(gen_right, gen_left, 1'b0, '0);
    endtask

    // Result side: random stalls, then hold ready until a word moves
    initial
    begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = no_stall ? 0 : $urandom_range(GapMax, 0);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        pose_t got;
        pose_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[222:0];
            if (pose_queue.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pose_queue.pop_front();
                if (got.x !== want.x)
                begin
                    $error("x_pos expected %0d actual %0d", want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y)
                begin
                    $error("y_pos expected %0d actual %0d", want.y, got.y);
                    errors++;
                end
                if (got.heading !== want.heading)
                begin
                    $error("heading_out expected %0d actual %0d", want.heading, got.heading);
                    errors++;
                end
                if (got.rs !== want.rs)
                begin
                    $error("right_speed expected %0d actual %0d", want.rs, got.rs);
                    errors++;
                end
                if (got.ls !== want.ls)
                begin
                    $error("left_speed expected %0d actual %0d", want.ls, got.ls);
                    errors++;
                end
                if (got.lin !== want.lin)
                begin
                    $error("linear_speed expected %0d actual %0d", want.lin, got.lin);
                    errors++;
                end
                if (got.ang !== want.ang)
                begin
                    $error("angular_speed expected %0d actual %0d", want.ang, got.ang);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word and no register access
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("diff_drive_odometry: mismatch");
            $finish;
        end
    end

    initial
    begin
        tick_row_t rows[$];
        logic [31:0] dist_cfg[PhaseCount];
        logic [31:0] invtw_cfg[PhaseCount];
        logic [31:0] rate_cfg[PhaseCount];

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        idle_cycles = 0;
        no_stall = 0;
        dist_reg = 32'd69578;
        invtw_reg = 24'd327680;
        rate_reg = 16'd250;
        last_right = '0;
        last_left = '0;
        x_state = '0;
        y_state = '0;
        heading_state = '0;
        gen_right = '0;
        gen_left = '0;

        // Directed ticks: standstill after reset, first tick, turns that
        // wrap the heading, huge steps and 32-bit count wrap
        rows = '{
            '{32'sd0, 32'sd0, 1'b1, '0},
            '{32'sd1000, -32'sd1000, 1'b0, '0},
            '{32'sd11000, 32'sd9000, 1'b0, '0},
            '{32'sd21000, 32'sd19000, 1'b0, '0},
            '{32'sd31000, 32'sd29000, 1'b0, '0},
            '{32'sd41000, 32'sd39000, 1'b0, '0},
            '{32'sd41000, 32'sd39000, 1'b0, '0},
            '{32'sd31000, 32'sd49000, 1'b0, '0},
            '{32'sd21000, 32'sd59000, 1'b0, '0},
            '{32'sd11000, 32'sd69000, 1'b0, '0},
            '{32'sh7fffffff, 32'sh80000000, 1'b0, '0},
            '{32'sh80000000, 32'sh7fffffff, 1'b0, '0},
            '{-32'sd1, -32'sd1, 1'b0, '0},
            '{32'sd0, 32'sd0, 1'b0, '0},
            '{32'sh7fffffff, 32'sh7fffffff, 1'b0, '0},
            '{32'sh80000000, 32'sh80000000, 1'b0, '0},
            '{32'sh55555555, 32'shaaaaaaaa, 1'b0, '0},
            '{32'shaaaaaaaa, 32'sh55555555, 1'b0, '0},
            '{32'sh2000000, -32'sh2000000, 1'b0, '0},
            '{32'sh4000000, -32'sh4000000, 1'b0, '0}
        };

        // Register settings per phase, extremes first, zero rate among them
        dist_cfg = '{32'd69578, 32'd0, 32'hffffffff, 32'd69578, 32'd1,
                     $urandom(), $urandom(), $urandom(), $urandom()};
        invtw_cfg = '{32'd327680, 32'd0, 32'hffffff, 32'hffffff, 32'd1,
                      $urandom(), $urandom(), 32'd327680, $urandom()};
        rate_cfg = '{32'd250, 32'd1, 32'd65535, 32'd0, 32'd65535,
                     $urandom_range(65535, 1), $urandom_range(65535, 1),
                     $urandom_range(1000, 1), $urandom_range(65535, 1)};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_tick(rows[i].right, rows[i].left, rows[i].fixed, rows[i].pose);

        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            // Hold the sender until the block is idle, then reprogram
            if (ph > 0)
            begin
                s_tvalid <= 1'b0;
                drain();
                reg_write(AddrDist, dist_cfg[ph]);
                reg_write(AddrInvTw, invtw_cfg[ph]);
                reg_write(AddrRate, rate_cfg[ph]);
                reg_write(AddrUnused, $urandom());
            end
            no_stall = (ph % 3 == 2);
            for (int k = 0; k < ItemsPerPhase; k++)
                send_random();
        end
        s_tvalid <= 1'b0;

        drain();
        if (errors == 0)
            $display("diff_drive_odometry: match");
        else
            $display("diff_drive_odometry: mismatch");
        $finish;
    end

endmodule
